/* hdl/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg: shared constants and types for the rotation matrix to Euler block
// Holds the CORDIC angle table and the fixed operand widths.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned IN_W   = 18;
  localparam int unsigned ANG_W  = 16;
  // CORDIC datapath width: 19-bit operand scaled by 256, grown by the gain
  localparam int unsigned CW     = 30;
  localparam int unsigned MAX_STAGES = 24;

  localparam logic [31:0] ANG_PI = 32'h8000_0000;

  typedef logic [31:0] angle_t;
  typedef logic signed [CW-1:0] cdata_t;

  function automatic angle_t atan_entry(input int unsigned i);
    angle_t v;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [ANG_W-1:0] to_bam(input angle_t z);
    angle_t t;
    t = z + 32'h0000_8000;
    return t[31:16];
  endfunction

endpackage

/* hdl/rotation_matrix_to_euler.sv */
// Pipeline: input register, 17 square-root stages, CORDIC_STAGES + 1 CORDIC stages and an
//   output register lie between input transfer and result valid.
// Throughput: one matrix per cycle; the whole pipe advances when the output slot
//   is free or being taken, so a stall holds every stage.
// Reset: rst_n synchronous, active low; clears valid bits only.
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler: ZYX Euler angles from a rotation matrix
// Square root stage, three parallel CORDIC pipes and an output register.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [17:0] in_r11,
  input  logic signed [17:0] in_r21,
  input  logic signed [17:0] in_r31,
  input  logic signed [17:0] in_r32,
  input  logic signed [17:0] in_r33,
  input  logic signed [17:0] in_r12,
  input  logic signed [17:0] in_r13,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic        out_gimbal_lock
);

  localparam int unsigned N  = (CORDIC_STAGES > rme_pkg::MAX_STAGES) ?
                               rme_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned SQ = 17;
  localparam int unsigned CL = N + 1;        // CORDIC pipeline stages
  localparam int unsigned DEPTH = 1 + SQ + CL; // stages before output register
  localparam int unsigned IW = rme_pkg::IN_W;

  // Whole pipe advances together; the last stage feeds the output register.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: register inputs, square r31, classify
  logic signed [IW-1:0] r11_r, r21_r, r31_r, r32_r, r33_r, r12_r, r13_r;
  logic                 v0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r11_r <= in_r11; r21_r <= in_r21; r31_r <= in_r31;
      r32_r <= in_r32; r33_r <= in_r33; r12_r <= in_r12; r13_r <= in_r13;
    end
  end

  logic lock_neg, lock_pos;
  assign lock_neg = (r31_r <= -18'sd65536);
  assign lock_pos = (r31_r >= 18'sd65536);

  logic [35:0] sq;
  logic [32:0] rad;
  always_comb begin
    sq  = $unsigned(36'(r31_r) * 36'(r31_r));
    rad = (lock_neg || lock_pos) ? 33'd0 : 33'(36'h1_0000_0000 - sq);
  end

  // tag carried through the square root: r31 plus lock flags
  localparam int unsigned TW = IW + 2;
  logic [TW-1:0] tag_o;
  logic [16:0]   root;
  rme_isqrt #(.TW(TW)) u_sqrt (
    .clk(clk), .en(en), .rad_i(rad), .tag_i({lock_pos, lock_neg, r31_r}),
    .root_o(root), .tag_o(tag_o)
  );

  // delay roll/yaw operands by the square root latency
  localparam int unsigned DW = 4 * IW;
  logic [DW-1:0] dl_r [SQ+1];
  always_comb begin
    // choose roll operands now: normal, or +-(r12, r13) under lock
    logic signed [IW:0] ry, rx;
    if (lock_neg) begin
      ry = 19'(r12_r); rx = 19'(r13_r);
    end else if (lock_pos) begin
      ry = -19'(r12_r); rx = -19'(r13_r);
    end else begin
      ry = 19'(r32_r); rx = 19'(r33_r);
    end
    dl_r[0] = {ry[IW-1:0], rx[IW-1:0], r21_r, r11_r};
  end
  // lock negation of -131072..131071 stays in 18 bits except -(-2^17); keep top bits
  logic [1:0] rs_r [SQ+1];
  always_comb begin
    logic signed [IW:0] a, b;
    a = lock_pos ? -19'(r12_r) : (lock_neg ? 19'(r12_r) : 19'(r32_r));
    b = lock_pos ? -19'(r13_r) : (lock_neg ? 19'(r13_r) : 19'(r33_r));
    rs_r[0] = {a[IW], b[IW]};
  end
  for (genvar k = 0; k < SQ; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[k+1] <= dl_r[k];
        rs_r[k+1] <= rs_r[k];
      end
    end
  end

  logic signed [IW:0] roll_y, roll_x, yaw_y, yaw_x, pit_y, pit_x;
  always_comb begin
    roll_y = {rs_r[SQ][1], dl_r[SQ][4*IW-1:3*IW]};
    roll_x = {rs_r[SQ][0], dl_r[SQ][3*IW-1:2*IW]};
    yaw_y  = 19'($signed(dl_r[SQ][2*IW-1:IW]));
    yaw_x  = 19'($signed(dl_r[SQ][IW-1:0]));
    pit_y  = 19'($signed(tag_o[IW-1:0]));
    pit_x  = $signed({2'b00, root});
  end

  rme_pkg::angle_t z_roll, z_yaw, z_pit;
  rme_cordic #(.STAGES(N)) u_roll (.clk(clk), .en(en), .y_i(roll_y), .x_i(roll_x), .z_o(z_roll));
  rme_cordic #(.STAGES(N)) u_yaw  (.clk(clk), .en(en), .y_i(yaw_y),  .x_i(yaw_x),  .z_o(z_yaw));
  rme_cordic #(.STAGES(N)) u_pit  (.clk(clk), .en(en), .y_i(pit_y),  .x_i(pit_x),  .z_o(z_pit));

  // lock flags ride alongside the CORDIC pipes
  logic [1:0] lk_r [CL+1];
  assign lk_r[0] = tag_o[TW-1:IW];
  for (genvar k = 0; k < CL; k++) begin : g_lk
    always_ff @(posedge clk) begin
      if (en) lk_r[k+1] <= lk_r[k];
    end
  end

  // valid bits travel with the data
  logic [DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[DEPTH-2:0], in_valid};
      out_valid <= vld_r[DEPTH-1];
    end
  end
  assign v0_r = vld_r[0];

  // output register: hold while stalled
  logic lk_any;
  assign lk_any = lk_r[CL][0] | lk_r[CL][1];
  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_angle  <= rme_pkg::to_bam(z_roll);
      out_yaw_angle   <= lk_any ? 16'sd0 : rme_pkg::to_bam(z_yaw);
      out_gimbal_lock <= lk_any;
      if (lk_r[CL][0])      out_pitch_angle <= 16'sh4000;
      else if (lk_r[CL][1]) out_pitch_angle <= 16'shC000;
      else                  out_pitch_angle <= rme_pkg::to_bam(32'd0 - z_pit);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_angle))
    else $error("result changed while stalled");
  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_lock |-> out_yaw_angle == 16'sd0)
    else $error("yaw not zero under gimbal lock");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    en && v0_r |=> vld_r[1])
    else $error("valid bit lost");

endmodule

/* hdl/rme_isqrt.sv */
// ----------------------------------------------------------------------------
// rme_isqrt: pipelined integer square root
// One result bit per stage; c = floor(sqrt(2^32 - r31^2)) for |r31| < 2^16.
// The radicand is known to fit in 33 bits, so 17 stages resolve the root.
// ----------------------------------------------------------------------------
module rme_isqrt #(
  parameter int unsigned TW = 8
) (
  input  logic                clk,
  input  logic                en,
  input  logic [32:0]         rad_i,
  input  logic [TW-1:0]       tag_i,
  output logic [16:0]         root_o,
  output logic [TW-1:0]       tag_o
);

  localparam int unsigned NB = 17;

  logic [32:0]   rem_r  [NB+1];
  logic [16:0]   res_r  [NB+1];
  logic [TW-1:0] tag_r  [NB+1];

  always_comb begin
    rem_r[0] = rad_i;
    res_r[0] = '0;
    tag_r[0] = tag_i;
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int unsigned B = NB - 1 - k;
    logic [34:0] trial;
    logic [34:0] sq_nxt;
    always_comb begin
      // (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
      trial  = ({18'd0, res_r[k]} << (B + 1)) | (35'd1 << (2 * B));
      sq_nxt = {2'b00, rem_r[k]} - trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        if ({2'b00, rem_r[k]} >= trial) begin
          rem_r[k+1] <= sq_nxt[32:0];
          res_r[k+1] <= res_r[k] | (17'd1 << B);
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k];
        end
      end
    end
  end

  assign root_o = res_r[NB];
  assign tag_o  = tag_r[NB];

endmodule

/* hdl/rme_cordic.sv */
// ----------------------------------------------------------------------------
// rme_cordic: pipelined vectoring CORDIC giving atan2(y, x)
// One pre-rotation stage, then one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [rme_pkg::IN_W:0] y_i,
  input  logic signed [rme_pkg::IN_W:0] x_i,
  output rme_pkg::angle_t              z_o
);

  localparam int unsigned N = (STAGES > rme_pkg::MAX_STAGES) ? rme_pkg::MAX_STAGES : STAGES;

  rme_pkg::cdata_t x_r [N+1];
  rme_pkg::cdata_t y_r [N+1];
  rme_pkg::angle_t z_r [N+1];
  logic            zero_r [N+1];

  rme_pkg::cdata_t xs, ys;
  always_comb begin
    xs = rme_pkg::cdata_t'(x_i) <<< 8;
    ys = rme_pkg::cdata_t'(y_i) <<< 8;
  end

  // pre-rotation: fold the left half-plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (xs < 0) begin
        x_r[0] <= -xs;
        y_r[0] <= -ys;
        z_r[0] <= rme_pkg::ANG_PI;
      end else begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + rme_pkg::atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - rme_pkg::atan_entry(i);
        end
      end
    end
  end

  assign z_o = zero_r[N] ? '0 : z_r[N];

endmodule
